@@ design/ebcs_pkg.sv @@
// Shared types and constants of the bounded error code stack.
package ebcs_pkg;

    localparam int DEPTH_DEFAULT = 16;

    typedef logic signed [31:0] code_t;

    // Request kinds carried in req_type.
    localparam logic [2:0] REQ_PUSH     = 3'd0;
    localparam logic [2:0] REQ_POP      = 3'd1;
    localparam logic [2:0] REQ_CLEAR    = 3'd2;
    localparam logic [2:0] REQ_CONTAINS = 3'd3;
    localparam logic [2:0] REQ_READ     = 3'd4;
    localparam logic [2:0] REQ_FLUSH    = 3'd5;

    typedef struct packed {
        logic [2:0] req_type;
        code_t      code;
        logic [3:0] position;
    } ebcs_req_t;

    typedef struct packed {
        logic       ok;
        code_t      code_out;
        logic [4:0] fill_level;
    } ebcs_res_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_MARK,
        ST_SORT,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_PUSH,
        CELL_DOWN,
        CELL_MARK,
        CELL_SORT
    } cell_cmd_t;

    typedef struct packed {
        cell_cmd_t cmd;
        logic      parity;
        code_t     code;
    } cell_ctl_t;

endpackage

@@ design/ebcs_cell.sv @@
// One stack cell: holds one entry and a keep mark, exchanges data with its neighbors.
module ebcs_cell (
    input  logic               clk,
    input  ebcs_pkg::cell_ctl_t ctl,
    input  logic               lane_odd,
    input  logic               in_range,
    input  ebcs_pkg::code_t    left_ent,
    input  logic               left_keep,
    input  ebcs_pkg::code_t    right_ent,
    input  logic               right_keep,
    output ebcs_pkg::code_t    ent,
    output logic               keep
);
    import ebcs_pkg::*;

    code_t ent_reg;
    code_t ent_next;
    logic  keep_reg;
    logic  keep_next;
    logic  lower;

    // In a sort phase this cell pairs with its right neighbor when the parities agree.
    assign lower = (ctl.parity == lane_odd);

    always_comb
    begin
        ent_next  = ent_reg;
        keep_next = keep_reg;
        case (ctl.cmd)
            CELL_PUSH: ent_next = left_ent;
            CELL_DOWN: ent_next = right_ent;
            CELL_MARK: keep_next = in_range && (ent_reg != ctl.code);
            CELL_SORT:
            begin
                // Kept entries move toward the top; dropped ones never pass each other's order.
                if (lower)
                begin
                    if (!keep_reg && right_keep)
                    begin
                        ent_next  = right_ent;
                        keep_next = 1'b1;
                    end
                end
                else if (!left_keep && keep_reg)
                begin
                    ent_next  = left_ent;
                    keep_next = 1'b0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        ent_reg  <= ent_next;
        keep_reg <= keep_next;
    end

    assign ent  = ent_reg;
    assign keep = keep_reg;

endmodule

@@ design/bounded_error_code_stack.sv @@
// Top level of the bounded error code stack: cell row, sequencer and output register.
//
// Requests enter on req/req_valid/req_stall; a transaction completes when req_valid
// is high and req_stall is low. Each request yields one result on res/res_valid/
// res_stall. The stack is a row of DEPTH cells with the top entry in cell 0.
// Push, pop, clear and unused request kinds set the result register on acceptance;
// it passes to the output register from the done state. Contains and read rotate the
// cell ring once, one entry per cycle past cell 0. Flush rotates the ring to count
// survivors, marks the entries to keep, then runs DEPTH odd-even exchange phases to
// compact them. One request is in work at a time; req_stall is low only while the
// sequencer is idle, so with an open receiver a new request is taken in the cycle
// after the previous result is loaded. A new request is taken while the previous
// result still waits in the output register. When res_stall holds the result, a
// finished request waits until the output register frees. Reset empties the stack
// (fill count zero) and sets empty_code to all ones; entries are not cleared.
// empty_code is written through empty_code_we and empty_code_data; the user must
// write it only while idle, which the block leaves unchecked.
module bounded_error_code_stack #(
    parameter int DEPTH = ebcs_pkg::DEPTH_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  ebcs_pkg::ebcs_req_t req,
    output logic                res_valid,
    input  logic                res_stall,
    output ebcs_pkg::ebcs_res_t res,
    input  logic                empty_code_we,
    input  ebcs_pkg::code_t     empty_code_data
);
    import ebcs_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam int FW = $clog2(DEPTH + 1);
    localparam int TW = (FW > 4) ? FW : 4;

    state_t          state_reg, state_next;
    logic [FW-1:0]   fill_reg, fill_next;
    logic [IW-1:0]   k_reg, k_next;
    code_t           code_reg, code_next;
    logic [2:0]      kind_reg, kind_next;
    logic [IW-1:0]   tgt_reg, tgt_next;
    logic            rd_ok_reg, rd_ok_next;
    logic            found_reg, found_next;
    logic [FW-1:0]   surv_reg, surv_next;
    code_t           rd_reg, rd_next;
    ebcs_res_t       res_reg, res_next;
    ebcs_res_t       out_reg, out_next;
    logic            out_valid_reg, out_valid_next;
    code_t           empty_code_reg;

    cell_ctl_t       ctl;
    code_t           ent_c [DEPTH];
    logic            keep_c [DEPTH];
    logic            in_rng_c [DEPTH];

    logic            k_last;
    logic            out_free;
    logic            walk_rng;
    logic            walk_eq;
    logic            found_now;
    logic [FW-1:0]   surv_now;
    code_t           rd_now;
    logic [TW-1:0]   tgt_full;
    logic            pos_ok;

    // ---------------- cell row ----------------
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        code_t ln_ent;
        logic  ln_keep;
        code_t rn_ent;
        logic  rn_keep;

        if (g == 0)
        begin : g_first
            assign ln_ent  = ctl.code;
            assign ln_keep = 1'b1;
        end
        else
        begin : g_mid_l
            assign ln_ent  = ent_c[g-1];
            assign ln_keep = keep_c[g-1];
        end

        if (g == DEPTH - 1)
        begin : g_last
            assign rn_ent  = ent_c[0];
            assign rn_keep = 1'b0;
        end
        else
        begin : g_mid_r
            assign rn_ent  = ent_c[g+1];
            assign rn_keep = keep_c[g+1];
        end

        assign in_rng_c[g] = (FW'(g) < fill_reg);

        ebcs_cell u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .lane_odd   (1'(g % 2)),
            .in_range   (in_rng_c[g]),
            .left_ent   (ln_ent),
            .left_keep  (ln_keep),
            .right_ent  (rn_ent),
            .right_keep (rn_keep),
            .ent        (ent_c[g]),
            .keep       (keep_c[g])
        );
    end

    // ---------------- walk datapath ----------------
    assign k_last    = (k_reg == IW'(DEPTH - 1));
    assign out_free  = !out_valid_reg || !res_stall;
    assign walk_rng  = (FW'(k_reg) < fill_reg);
    assign walk_eq   = (ent_c[0] == code_reg);
    assign found_now = found_reg || (walk_rng && walk_eq);
    assign surv_now  = surv_reg + FW'(walk_rng && !walk_eq);
    assign rd_now    = (rd_ok_reg && (k_reg == tgt_reg)) ? ent_c[0] : rd_reg;

    // Position counts from the bottom, which sits in cell fill - 1.
    assign tgt_full  = TW'(fill_reg) - TW'(1) - TW'(req.position);
    assign pos_ok    = (TW'(req.position) < TW'(fill_reg));

    // ---------------- next state ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    if (req.req_type == REQ_CONTAINS || req.req_type == REQ_READ ||
                        req.req_type == REQ_FLUSH)
                        state_next = ST_WALK;
                    else
                        state_next = ST_DONE;
                end
            end
            ST_WALK:
            begin
                if (k_last)
                    state_next = (kind_reg == REQ_FLUSH) ? ST_MARK : ST_DONE;
            end
            ST_MARK: state_next = ST_SORT;
            ST_SORT:
            begin
                if (k_last)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ---------------- outputs and datapath control ----------------
    always_comb
    begin
        ctl.cmd        = CELL_HOLD;
        ctl.parity     = k_reg[0];
        ctl.code       = code_reg;
        fill_next      = fill_reg;
        k_next         = k_reg;
        code_next      = code_reg;
        kind_next      = kind_reg;
        tgt_next       = tgt_reg;
        rd_ok_next     = rd_ok_reg;
        found_next     = found_reg;
        surv_next      = surv_reg;
        rd_next        = rd_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && res_stall;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    code_next           = req.code;
                    kind_next           = req.req_type;
                    tgt_next            = tgt_full[IW-1:0];
                    rd_ok_next          = pos_ok;
                    k_next              = '0;
                    found_next          = 1'b0;
                    surv_next           = '0;
                    rd_next             = empty_code_reg;
                    res_next.ok         = 1'b0;
                    res_next.code_out   = empty_code_reg;
                    case (req.req_type)
                        REQ_PUSH:
                        begin
                            res_next.ok = 1'b1;
                            // A code equal to the current top is not pushed again.
                            if (!(fill_reg != '0 && ent_c[0] == req.code))
                            begin
                                ctl.cmd  = CELL_PUSH;
                                ctl.code = req.code;
                                if (fill_reg != FW'(DEPTH))
                                    fill_next = fill_reg + FW'(1);
                            end
                        end
                        REQ_POP:
                        begin
                            if (fill_reg != '0)
                            begin
                                ctl.cmd           = CELL_DOWN;
                                fill_next         = fill_reg - FW'(1);
                                res_next.ok       = 1'b1;
                                res_next.code_out = ent_c[0];
                            end
                        end
                        REQ_CLEAR:
                        begin
                            fill_next   = '0;
                            res_next.ok = 1'b1;
                        end
                        default: ;
                    endcase
                    res_next.fill_level = 5'(fill_next);
                end
            end
            ST_WALK:
            begin
                ctl.cmd    = CELL_DOWN;
                k_next     = k_last ? '0 : k_reg + IW'(1);
                found_next = found_now;
                surv_next  = surv_now;
                rd_next    = rd_now;
                if (k_last)
                begin
                    res_next.fill_level = 5'(fill_reg);
                    res_next.code_out   = empty_code_reg;
                    res_next.ok         = 1'b0;
                    case (kind_reg)
                        REQ_CONTAINS: res_next.ok = found_now;
                        REQ_READ:
                        begin
                            res_next.ok = rd_ok_reg;
                            if (rd_ok_reg)
                                res_next.code_out = rd_now;
                        end
                        default: ;
                    endcase
                end
            end
            ST_MARK:
            begin
                ctl.cmd = CELL_MARK;
                k_next  = '0;
            end
            ST_SORT:
            begin
                ctl.cmd = CELL_SORT;
                k_next  = k_last ? '0 : k_reg + IW'(1);
                if (k_last)
                begin
                    fill_next           = surv_reg;
                    res_next.ok         = 1'b1;
                    res_next.code_out   = empty_code_reg;
                    res_next.fill_level = 5'(surv_reg);
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            fill_reg       <= '0;
            out_valid_reg  <= 1'b0;
            empty_code_reg <= '1;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
            if (empty_code_we)
                empty_code_reg <= empty_code_data;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg     <= k_next;
        code_reg  <= code_next;
        kind_reg  <= kind_next;
        tgt_reg   <= tgt_next;
        rd_ok_reg <= rd_ok_next;
        found_reg <= found_next;
        surv_reg  <= surv_next;
        rd_reg    <= rd_next;
        res_reg   <= res_next;
        out_reg   <= out_next;
    end

    assign req_stall = (state_reg != ST_IDLE);
    assign res_valid = out_valid_reg;
    assign res       = out_reg;

`ifndef SYNTH
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FW'(DEPTH))
        else $error("fill count above stack depth");

    a_push_fills: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall && req.req_type == REQ_PUSH) |=> (fill_reg != '0))
        else $error("stack empty after a push");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall && req.req_type == REQ_CLEAR) |=> (fill_reg == '0))
        else $error("stack not empty after a clear");

    a_done_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && out_free) |=> (res_valid && res == $past(res_reg)))
        else $error("finished result not moved to the output register");
`endif

endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench for bounded_error_code_stack with a built-in stack predictor.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ebcs_pkg::*;

    localparam int STACK_DEPTH = DEPTH_DEFAULT;
    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES = 2 * STACK_DEPTH + 8;
    localparam int MAX_PRINTED = 60;

    // Request kinds the block must ignore.
    localparam logic [2:0] REQ_UNUSED_6 = 3'd6;
    localparam logic [2:0] REQ_UNUSED_7 = 3'd7;

    logic      clk;
    logic      rst_n;
    logic      req_valid;
    logic      req_stall;
    ebcs_req_t req;
    logic      res_valid;
    logic      res_stall;
    ebcs_res_t res;
    logic      empty_code_we;
    code_t     empty_code_data;

    // Predictor state: bottom of the stack at index 0.
    code_t stack_mem [STACK_DEPTH];
    int    stack_fill;
    code_t empty_model;

    ebcs_res_t pending_results [$];
    code_t     code_pool [6];

    int  cycle_count = 0;
    int  error_count;
    int  results_checked;
    int  kind_count [8];
    int  full_pushes;
    int  underflows;
    int  setting_count;
    int  idle_odds;
    bit  hold_long;

    bounded_error_code_stack #(
        .DEPTH(STACK_DEPTH)
    ) dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_valid       (req_valid),
        .req_stall       (req_stall),
        .req             (req),
        .res_valid       (res_valid),
        .res_stall       (res_stall),
        .res             (res),
        .empty_code_we   (empty_code_we),
        .empty_code_data (empty_code_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Timed out after %0d cycles with %0d results outstanding.",
                 cycle_count, pending_results.size());
        $display("FAIL bounded_error_code_stack");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        if (error_count < MAX_PRINTED)
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        error_count++;
    endtask

    // Applies one request to the predicted stack and returns the expected result.
    function automatic ebcs_res_t stack_predict(input ebcs_req_t r);
        ebcs_res_t o;
        int        i;
        int        keep;
        o.ok = 1'b0;
        o.code_out = empty_model;
        case (r.req_type)
            REQ_PUSH:
            begin
                o.ok = 1'b1;
                if (!(stack_fill > 0 && stack_mem[stack_fill - 1] == r.code))
                begin
                    if (stack_fill == STACK_DEPTH)
                    begin
                        for (i = 1; i < STACK_DEPTH; i++)
                            stack_mem[i - 1] = stack_mem[i];
                        stack_fill--;
                        full_pushes++;
                    end
                    stack_mem[stack_fill] = r.code;
                    stack_fill++;
                end
            end
            REQ_POP:
            begin
                if (stack_fill > 0)
                begin
                    stack_fill--;
                    o.code_out = stack_mem[stack_fill];
                    o.ok = 1'b1;
                end
                else
                    underflows++;
            end
            REQ_CLEAR:
            begin
                stack_fill = 0;
                o.ok = 1'b1;
            end
            REQ_CONTAINS:
            begin
                for (i = 0; i < stack_fill; i++)
                    if (stack_mem[i] == r.code)
                        o.ok = 1'b1;
            end
            REQ_READ:
            begin
                if (int'(r.position) < stack_fill)
                begin
                    o.code_out = stack_mem[r.position];
                    o.ok = 1'b1;
                end
            end
            REQ_FLUSH:
            begin
                keep = 0;
                for (i = 0; i < stack_fill; i++)
                begin
                    if (stack_mem[i] != r.code)
                    begin
                        stack_mem[keep] = stack_mem[i];
                        keep++;
                    end
                end
                stack_fill = keep;
                o.ok = 1'b1;
            end
            default:
            begin
            end
        endcase
        o.fill_level = 5'(stack_fill);
        return o;
    endfunction

    // Both handshakes are observed at the rising edge, before the block updates.
    always @(posedge clk)
    begin
        ebcs_res_t want;
        if (rst_n)
        begin
            if (res_valid && !res_stall)
            begin
                if (pending_results.size() == 0)
                    report_mismatch($sformatf(
                        "result with nothing expected: ok %0b code %h fill %0d",
                        res.ok, res.code_out, res.fill_level));
                else
                begin
                    want = pending_results.pop_front();
                    results_checked++;
                    if (res.ok !== want.ok)
                        report_mismatch($sformatf("ok: expected %0b, got %0b", want.ok, res.ok));
                    if (res.code_out !== want.code_out)
                        report_mismatch($sformatf("code_out: expected %h, got %h",
                                                  want.code_out, res.code_out));
                    if (res.fill_level !== want.fill_level)
                        report_mismatch($sformatf("fill_level: expected %0d, got %0d",
                                                  want.fill_level, res.fill_level));
                end
            end
            if (req_valid && !req_stall)
            begin
                pending_results.push_back(stack_predict(req));
                kind_count[req.req_type]++;
            end
        end
    end

    // Receiver: random stall bursts, plus one long hold on request.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_long)
            begin
                res_stall = 1'b1;
                repeat (LONG_HOLD_CYCLES) @(negedge clk);
                res_stall = 1'b0;
                hold_long = 1'b0;
            end
            else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
            begin
                res_stall = 1'b1;
                repeat ($urandom_range(1, 18)) @(negedge clk);
                res_stall = 1'b0;
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic send_request(input logic [2:0] kind, input code_t c, input logic [3:0] p);
        if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
        begin
            req_valid = 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
        req.req_type = kind;
        req.code = c;
        req.position = p;
        req_valid = 1'b1;
        do
            @(posedge clk);
        while (req_stall);
        @(negedge clk);
        // Released here unless the next transaction follows at once.
        req_valid = 1'b0;
    endtask

    task automatic wait_for_results();
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_empty_code(input code_t v);
        wait_for_results();
        empty_code_data = v;
        empty_code_we = 1'b1;
        @(negedge clk);
        empty_code_we = 1'b0;
        empty_model = v;
        setting_count++;
    endtask

    task automatic refresh_pool();
        int i;
        code_pool[0] = 32'sh80000000;
        code_pool[1] = 32'sh7fffffff;
        for (i = 2; i < 6; i++)
            code_pool[i] = code_t'($urandom);
    endtask

    function automatic code_t pick_code();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 7)
            return code_pool[$urandom_range(0, 5)];
        if (roll == 7)
            return empty_model;
        return code_t'($urandom);
    endfunction

    // Mostly pushes and lookups on a small code pool, so hits and duplicates are common.
    task automatic run_random_batch(input int n, input int push_pct);
        int         k;
        int         roll;
        logic [2:0] kind;
        logic [3:0] p;
        for (k = 0; k < n; k++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < push_pct)
                kind = REQ_PUSH;
            else
            begin
                roll = $urandom_range(0, 99);
                if (roll < 30)
                    kind = REQ_POP;
                else if (roll < 52)
                    kind = REQ_CONTAINS;
                else if (roll < 76)
                    kind = REQ_READ;
                else if (roll < 92)
                    kind = REQ_FLUSH;
                else if (roll < 96)
                    kind = REQ_CLEAR;
                else if (roll < 98)
                    kind = REQ_UNUSED_6;
                else
                    kind = REQ_UNUSED_7;
            end
            if (stack_fill > 0 && $urandom_range(0, 1) == 1)
                p = 4'($urandom_range(0, stack_fill - 1));
            else
                p = 4'($urandom_range(0, 15));
            send_request(kind, pick_code(), p);
        end
    endtask

    task automatic test_empty_stack();
        send_request(REQ_POP, 32'sd0, 4'd0);
        send_request(REQ_READ, 32'sd0, 4'd0);
        send_request(REQ_READ, 32'sd0, 4'd15);
        send_request(REQ_CONTAINS, empty_model, 4'd0);
        send_request(REQ_FLUSH, 32'sd0, 4'd0);
        send_request(REQ_UNUSED_6, 32'sh7fffffff, 4'd15);
        wait_for_results();
    endtask

    // Duplicate top, overflow of a full stack, reads at both ends, flush of repeats.
    task automatic test_push_rules();
        int i;
        send_request(REQ_PUSH, 32'sh80000000, 4'd0);
        send_request(REQ_PUSH, 32'sh80000000, 4'd0);
        send_request(REQ_PUSH, 32'sh7fffffff, 4'd0);
        send_request(REQ_PUSH, 32'sd0, 4'd0);
        for (i = 0; i < STACK_DEPTH - 3; i++)
            send_request(REQ_PUSH, code_t'(32'h5a5a_0000 + i), 4'd0);
        send_request(REQ_PUSH, 32'sh7fffffff, 4'd0);
        send_request(REQ_CONTAINS, 32'sh80000000, 4'd0);
        send_request(REQ_READ, 32'sd0, 4'd0);
        send_request(REQ_READ, 32'sd0, 4'd15);
        send_request(REQ_FLUSH, 32'sh7fffffff, 4'd0);
        send_request(REQ_POP, 32'sd0, 4'd0);
        send_request(REQ_CLEAR, 32'sd0, 4'd0);
        send_request(REQ_UNUSED_7, 32'sh80000000, 4'd0);
        wait_for_results();
    endtask

    task automatic test_empty_code_settings();
        code_t settings [5];
        int    push_mix [5];
        int    odds [5];
        int    ph;
        refresh_pool();
        settings = '{32'sh80000000, 32'sh7fffffff, 32'sd0, code_t'($urandom), code_pool[2]};
        push_mix = '{60, 30, 70, 45, 50};
        odds = '{4, 2, 0, 6, 3};
        for (ph = 0; ph < 5; ph++)
        begin
            write_empty_code(settings[ph]);
            idle_odds = odds[ph];
            run_random_batch(110, push_mix[ph]);
            refresh_pool();
        end
        wait_for_results();
    endtask

    task automatic test_full_backpressure();
        idle_odds = 5;
        hold_long = 1'b1;
        run_random_batch(60, 55);
        wait_for_results();
    endtask

    task automatic test_steady_stream();
        write_empty_code(32'shffffffff);
        idle_odds = 0;
        run_random_batch(100, 50);
        wait_for_results();
    endtask

    initial
    begin
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        res_stall = 1'b0;
        empty_code_we = 1'b0;
        empty_code_data = '0;
        error_count = 0;
        results_checked = 0;
        full_pushes = 0;
        underflows = 0;
        setting_count = 0;
        hold_long = 1'b0;
        idle_odds = 4;
        kind_count = '{default: 0};
        stack_mem = '{default: '0};
        stack_fill = 0;
        empty_model = 32'shffffffff;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_empty_stack();
        test_push_rules();
        test_empty_code_settings();
        test_full_backpressure();
        test_steady_stream();

        wait_for_results();
        repeat (SETTLE_CYCLES) @(negedge clk);

        $display("Checked %0d results: push %0d, pop %0d, clear %0d, contains %0d,",
                 results_checked, kind_count[REQ_PUSH], kind_count[REQ_POP],
                 kind_count[REQ_CLEAR], kind_count[REQ_CONTAINS]);
        $display("read %0d, flush %0d, unused %0d; full pushes %0d, underflows %0d.",
                 kind_count[REQ_READ], kind_count[REQ_FLUSH],
                 kind_count[REQ_UNUSED_6] + kind_count[REQ_UNUSED_7],
                 full_pushes, underflows);
        $display("Empty code settings %0d, %0d mismatches.", setting_count, error_count);
        if (error_count == 0)
            $display("PASS bounded_error_code_stack");
        else
            $display("FAIL bounded_error_code_stack");
        $finish;
    end

endmodule
